// ----- sv/first_fit_heap_allocator_top_defines.svh -----
// Assertion macros for the first-fit heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FFA_CHECK_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FFA_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ffa_pkg.sv -----
// Shared types and constants for the first-fit heap allocator
`default_nettype none

package ffa_pkg;

    localparam int unsigned HDR_BYTES = 9;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned REQ_W     = 12;
    localparam int unsigned OFS_W     = 12;
    localparam int unsigned ST_W      = 2;

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_NULL = 2'd1;
    localparam logic [ST_W-1:0] ST_OOM  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_APPEND,
        S_FOUND,
        S_REM_ADDR,
        S_REM_SIZE,
        S_MARK
    } state_t;

    // adder control: neg subtracts b, and the header too when hdr is set; hdr alone adds the header length
    typedef struct packed {
        logic neg;
        logic hdr;
    } alu_op_t;

    typedef struct packed {
        logic busy_we;
        logic size_we;
    } mem_we_t;

endpackage

`default_nettype wire

// ----- sv/ffa_alu.sv -----
// Shared adder and comparators used by every step of the sequencer
`default_nettype none

module ffa_alu #(
    parameter int unsigned W = 18
) (
    input  ffa_pkg::alu_op_t op,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    input  logic [W-1:0]     x,
    input  logic [W-1:0]     y,
    input  logic [W-1:0]     lim,
    output logic [W-1:0]     sum,
    output logic             ge,
    output logic             sum_ge
);
    import ffa_pkg::*;

    logic [W-1:0] b_term;
    logic [W-1:0] k_term;

    always_comb
    begin
        b_term = op.neg ? (~b + W'(1)) : b;
        if (op.hdr)
        begin
            k_term = op.neg ? (~W'(HDR_BYTES) + W'(1)) : W'(HDR_BYTES);
        end
        else
        begin
            k_term = '0;
        end
        sum    = a + b_term + k_term;
        ge     = (x >= y);
        sum_ge = (sum >= lim);
    end

endmodule

`default_nettype wire

// ----- sv/ffa_store.sv -----
// Header store: busy flags and block sizes, one write and one registered read port
`default_nettype none

module ffa_store #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic               clk,
    input  ffa_pkg::mem_we_t   we,
    input  logic [AW-1:0]      wr_addr,
    input  logic               wr_busy,
    input  logic [AW-1:0]      wr_size,
    input  logic [AW-1:0]      rd_addr,
    output logic               rd_busy,
    output logic [AW-1:0]      rd_size
);
    import ffa_pkg::*;

    // busy and size kept apart so a free can clear the flag alone
    logic          busy_mem [DEPTH];
    logic [AW-1:0] size_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we.busy_we)
        begin
            busy_mem[wr_addr] <= wr_busy;
        end
        if (we.size_we)
        begin
            size_mem[wr_addr] <= wr_size;
        end
        rd_busy <= busy_mem[rd_addr];
        rd_size <= size_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/first_fit_heap_allocator_top.sv -----
// First-fit heap allocator: sequencer, header store and shared adder
//
// Usage: drive opcode, request_bytes and handle and raise start; the command
// is taken at a clock edge where start is high and busy is low. Opcodes are
// init (empty the heap), allocate and free. Each command gives exactly one
// result: payload_offset and status valid for the single cycle that done is
// high. The receiver cannot hold results off.
// Sequence: init, free and unknown opcodes give done in the cycle after the
// transfer and never raise busy. An allocate walks one block header per cycle
// through the single read port of the header store; then a whole-block take
// passes found and mark, an append passes append and mark, a split passes
// found, remainder address, then remainder header write and mark, and out of
// memory ends at append. busy stays high for the whole walk and drops as done
// rises, so no new command is taken until the allocate is through.
// Reset clears the heap top and the sequencer; the header store is not
// cleared, as only headers on the block chain are ever read.
`default_nettype none
`include "first_fit_heap_allocator_top_defines.svh"

module first_fit_heap_allocator_top #(
    parameter int unsigned HEAP_BYTES = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ffa_pkg::OP_W-1:0]    opcode,
    input  logic [ffa_pkg::REQ_W-1:0]   request_bytes,
    input  logic [ffa_pkg::REQ_W-1:0]   handle,
    output logic                        done,
    output logic [ffa_pkg::OFS_W-1:0]   payload_offset,
    output logic [ffa_pkg::ST_W-1:0]    status
);
    import ffa_pkg::*;

    localparam int unsigned AW = $clog2(HEAP_BYTES);
    localparam int unsigned TW = AW + 1;
    localparam int unsigned W  = ((AW > REQ_W) ? AW : REQ_W) + 2;

    state_t            state_reg, state_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [TW-1:0]     heap_top_reg, heap_top_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [AW-1:0]     size_s_reg, size_s_next;
    logic [AW-1:0]     rem_reg, rem_next;
    logic              set_size_reg, set_size_next;
    logic              done_reg, done_next;
    logic [OFS_W-1:0]  payload_reg, payload_next;
    logic [ST_W-1:0]   status_reg, status_next;

    alu_op_t           alu_op;
    logic [W-1:0]      alu_a, alu_b, alu_x, alu_y, alu_lim, alu_sum;
    logic              alu_ge, alu_sum_ge;

    mem_we_t           mem_we;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic              wr_busy;
    logic [AW-1:0]     wr_size;
    logic              rd_busy;
    logic [AW-1:0]     rd_size;

    logic              accept;
    logic              found;
    logic              oom;
    logic              split;

    ffa_alu #(
        .W(W)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .x      (alu_x),
        .y      (alu_y),
        .lim    (alu_lim),
        .sum    (alu_sum),
        .ge     (alu_ge),
        .sum_ge (alu_sum_ge)
    );

    ffa_store #(
        .DEPTH(HEAP_BYTES),
        .AW   (AW)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wr_addr),
        .wr_busy (wr_busy),
        .wr_size (wr_size),
        .rd_addr (rd_addr),
        .rd_busy (rd_busy),
        .rd_size (rd_size)
    );

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign found  = !rd_busy && alu_ge;
    assign oom    = alu_sum_ge || alu_ge;
    // block size above request plus header: split off a remainder
    assign split  = !alu_sum_ge;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (opcode == OP_ALLOC))
                begin
                    state_next = (heap_top_reg == '0) ? S_APPEND : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (found)
                begin
                    state_next = S_FOUND;
                end
                else if (alu_sum_ge)
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:   state_next = oom ? S_IDLE : S_MARK;
            S_FOUND:    state_next = split ? S_REM_ADDR : S_MARK;
            S_REM_ADDR: state_next = S_REM_SIZE;
            S_REM_SIZE: state_next = S_MARK;
            S_MARK:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath control and register updates
    always_comb
    begin
        alu_op        = '0;
        alu_a         = '0;
        alu_b         = '0;
        alu_x         = '0;
        alu_y         = '0;
        alu_lim       = '0;
        mem_we        = '0;
        wr_addr       = pos_reg;
        wr_busy       = 1'b0;
        wr_size       = AW'(req_reg);
        rd_addr       = pos_reg;
        pos_next      = pos_reg;
        heap_top_next = heap_top_reg;
        req_next      = req_reg;
        size_s_next   = size_s_reg;
        rem_next      = rem_reg;
        set_size_next = set_size_reg;
        done_next     = 1'b0;
        payload_next  = payload_reg;
        status_next   = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // handle - 9, in range when handle >= 9 and handle - 9 is below heap size
                rd_addr    = '0;
                alu_op.neg = 1'b1;
                alu_op.hdr = 1'b1;
                alu_a      = W'(handle);
                alu_x      = W'(handle);
                alu_y      = W'(HDR_BYTES);
                alu_lim    = W'(HEAP_BYTES);
                if (accept)
                begin
                    req_next = request_bytes;
                    pos_next = '0;
                    case (opcode)
                        OP_INIT:
                        begin
                            heap_top_next = '0;
                            done_next     = 1'b1;
                            payload_next  = '0;
                            status_next   = ST_OK;
                        end
                        OP_ALLOC:
                        begin
                            done_next = 1'b0;
                        end
                        OP_FREE:
                        begin
                            done_next    = 1'b1;
                            payload_next = '0;
                            status_next  = (handle == '0) ? ST_NULL : ST_OK;
                            if (alu_ge && !alu_sum_ge)
                            begin
                                mem_we.busy_we = 1'b1;
                                wr_addr        = alu_sum[AW-1:0];
                                wr_busy        = 1'b0;
                            end
                        end
                        default:
                        begin
                            done_next    = 1'b1;
                            payload_next = '0;
                            status_next  = ST_OK;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                // next header offset; read it now in case this block misses
                alu_op.hdr = 1'b1;
                alu_a      = W'(pos_reg);
                alu_b      = W'(rd_size);
                alu_x      = W'(rd_size);
                alu_y      = W'(req_reg);
                alu_lim    = W'(heap_top_reg);
                rd_addr    = alu_sum[AW-1:0];
                if (found)
                begin
                    size_s_next = rd_size;
                end
                else
                begin
                    pos_next = alu_sum[AW-1:0];
                end
            end
            S_APPEND:
            begin
                alu_op.hdr = 1'b1;
                alu_a      = W'(heap_top_reg);
                alu_b      = W'(req_reg);
                alu_lim    = W'(HEAP_BYTES + 1);
                alu_x      = W'(heap_top_reg);
                alu_y      = W'(HEAP_BYTES - HDR_BYTES);
                if (oom)
                begin
                    done_next    = 1'b1;
                    payload_next = '0;
                    status_next  = ST_OOM;
                end
                else
                begin
                    heap_top_next = alu_sum[TW-1:0];
                    pos_next      = heap_top_reg[AW-1:0];
                    set_size_next = 1'b1;
                end
            end
            S_FOUND:
            begin
                alu_op.hdr    = 1'b1;
                alu_a         = W'(req_reg);
                alu_lim       = W'(size_s_reg);
                set_size_next = split;
            end
            S_REM_ADDR:
            begin
                alu_op.hdr = 1'b1;
                alu_a      = W'(pos_reg);
                alu_b      = W'(req_reg);
                rem_next   = alu_sum[AW-1:0];
            end
            S_REM_SIZE:
            begin
                alu_op.neg     = 1'b1;
                alu_op.hdr     = 1'b1;
                alu_a          = W'(size_s_reg);
                alu_b          = W'(req_reg);
                mem_we.busy_we = 1'b1;
                mem_we.size_we = 1'b1;
                wr_addr        = rem_reg;
                wr_busy        = 1'b0;
                wr_size        = alu_sum[AW-1:0];
            end
            S_MARK:
            begin
                alu_op.hdr     = 1'b1;
                alu_a          = W'(pos_reg);
                mem_we.busy_we = 1'b1;
                mem_we.size_we = set_size_reg;
                wr_addr        = pos_reg;
                wr_busy        = 1'b1;
                wr_size        = AW'(req_reg);
                done_next      = 1'b1;
                payload_next   = alu_sum[OFS_W-1:0];
                status_next    = ST_OK;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            heap_top_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            heap_top_reg <= heap_top_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        req_reg      <= req_next;
        size_s_reg   <= size_s_next;
        rem_reg      <= rem_next;
        set_size_reg <= set_size_next;
        payload_reg  <= payload_next;
        status_reg   <= status_next;
    end

    assign done           = done_reg;
    assign payload_offset = payload_reg;
    assign status         = status_reg;

    `FFA_CHECK_NEXT(a_alloc_walks, accept && (opcode == OP_ALLOC), busy, "allocate did not start")
    `FFA_CHECK_NEXT(a_quick_done, accept && (opcode != OP_ALLOC), done && !busy, "missing result")
    `FFA_CHECK_SAME(a_top_bound, 1'b1, heap_top_reg <= TW'(HEAP_BYTES), "heap top past capacity")
    `FFA_CHECK_SAME(a_err_zero, done && (status != ST_OK), payload_offset == '0, "error offset")

endmodule

`default_nettype wire
